// ===== rtl/ctcgd_pkg.sv =====
// ctcgd_pkg: shared constants, exp tables and the step record for the ctc greedy decoder
// no dependencies
package ctcgd_pkg;

    localparam int MAX_CLASSES   = 128;
    localparam int MAX_TIMESTEPS = 256;

    localparam int CLS_W   = $clog2(MAX_CLASSES);
    localparam int CNT_W   = $clog2(MAX_TIMESTEPS + 1);
    localparam int SCORE_W = 16;
    localparam int SUM_W   = 24;
    localparam int Q_W     = 17;
    localparam int TOT_W   = $clog2(MAX_TIMESTEPS * 65536 + 1);
    localparam int CHAR_W  = 7;
    localparam int VOC_W   = 8;

    localparam int DIV_NW  = 34;
    localparam int DIV_DW  = (TOT_W > SUM_W + 1) ? TOT_W : SUM_W + 1;

    localparam logic [Q_W-1:0]   Q_ONE   = 17'h10000;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CLS_W-1:0] CLS_TOP = CLS_W'(MAX_CLASSES - 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_TIMESTEPS);

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_VOCAB     = 1'b1;

    typedef struct packed {
        logic [CLS_W-1:0]          cls;
        logic signed [SCORE_W-1:0] scr;
        logic [SUM_W-1:0]          sum;
        logic                      seq_end;
    } t_step_rec;

    function automatic logic [Q_W-1:0] exp_int(input logic [3:0] i);
        logic [Q_W-1:0] v;
        unique case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [Q_W-1:0] exp_hi(input logic [3:0] k);
        logic [Q_W-1:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57835;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32953;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29082;
            4'd14: v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [Q_W-1:0] exp_lo(input logic [3:0] k);
        logic [Q_W-1:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd65280;
            4'd2:  v = 17'd65026;
            4'd3:  v = 17'd64772;
            4'd4:  v = 17'd64520;
            4'd5:  v = 17'd64268;
            4'd6:  v = 17'd64018;
            4'd7:  v = 17'd63768;
            4'd8:  v = 17'd63520;
            4'd9:  v = 17'd63272;
            4'd10: v = 17'd63025;
            4'd11: v = 17'd62780;
            4'd12: v = 17'd62535;
            4'd13: v = 17'd62291;
            4'd14: v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ctcgd_front.sv =====
// ctcgd_front: takes score beats, tracks running max and rescaled exp sum per timestep
// depends on ctcgd_pkg
module ctcgd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [15:0]             i_score,
    input  logic                           i_last_in_step,
    input  logic                           i_last_in_sequence,
    output logic                           o_push,
    output ctcgd_pkg::t_step_rec           o_rec,
    input  logic                           i_full
);
    import ctcgd_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_E1   = 2'd1;
    localparam logic [1:0] F_E2   = 2'd2;
    localparam logic [1:0] F_UPD  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_end_step, r_end_seq, r_up, r_first;
    logic [15:0]               r_diff;
    logic [Q_W-1:0]            r_t1, r_e;
    logic [CLS_W-1:0]          r_pos, r_cls;
    logic signed [SCORE_W-1:0] r_best;
    logic [SUM_W-1:0]          r_sum;

    logic                      accept;
    logic signed [16:0]        diff_full;
    logic [Q_W-1:0]            a_val;
    logic [33:0]               prod1, prod2;
    logic [41:0]               prod3;
    logic [25:0]               up_sum;
    logic [24:0]               add_sum;
    logic [CLS_W-1:0]          n_cls;
    logic signed [SCORE_W-1:0] n_best;
    logic [SUM_W-1:0]          n_sum;
    logic                      closing;

    assign accept    = i_valid && (r_state == F_IDLE);
    assign o_stall   = (r_state != F_IDLE);
    assign diff_full = (i_score > r_best) ? (17'(i_score) - 17'(r_best))
                                          : (17'(r_best) - 17'(i_score));
    assign a_val     = (r_diff[15:8] > 8'd11) ? '0 : exp_int(r_diff[11:8]);
    assign prod1     = 34'(a_val) * 34'(exp_hi(r_diff[7:4])) + 34'd32768;
    assign prod2     = 34'(r_t1) * 34'(exp_lo(r_diff[3:0])) + 34'd32768;
    assign prod3     = 42'(r_sum) * 42'(r_e) + 42'd32768;
    assign up_sum    = 26'(prod3[41:16]) + 26'(Q_ONE);
    assign add_sum   = 25'(r_sum) + 25'(r_e);
    assign closing   = r_end_step || r_end_seq;

    always_comb begin
        if (r_first) begin
            n_cls  = '0;
            n_best = r_score;
            n_sum  = SUM_W'(Q_ONE);
        end else if (r_up) begin
            n_cls  = r_pos;
            n_best = r_score;
            n_sum  = (up_sum > 26'(SUM_MAX)) ? SUM_MAX : up_sum[SUM_W-1:0];
        end else begin
            n_cls  = r_cls;
            n_best = r_best;
            n_sum  = (add_sum > 25'(SUM_MAX)) ? SUM_MAX : add_sum[SUM_W-1:0];
        end
    end

    assign o_push        = (r_state == F_UPD) && closing && !i_full;
    assign o_rec.cls     = n_cls;
    assign o_rec.scr     = n_best;
    assign o_rec.sum     = n_sum;
    assign o_rec.seq_end = r_end_seq;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_E1;
            F_E1:   n_state = F_E2;
            F_E2:   n_state = F_UPD;
            F_UPD:  if (!closing || !i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_pos   <= '0;
            r_cls   <= '0;
            r_best  <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_UPD && (!closing || !i_full)) begin
                if (closing) begin
                    r_pos  <= '0;
                    r_cls  <= '0;
                    r_best <= '0;
                    r_sum  <= '0;
                end else begin
                    r_pos  <= (r_pos == CLS_TOP) ? CLS_TOP : r_pos + 1'b1;
                    r_cls  <= n_cls;
                    r_best <= n_best;
                    r_sum  <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_score    <= i_score;
            r_end_step <= i_last_in_step;
            r_end_seq  <= i_last_in_sequence;
            r_up       <= i_score > r_best;
            r_first    <= (r_pos == '0);
            r_diff     <= diff_full[15:0];
        end
        if (r_state == F_E1) r_t1 <= prod1[32:16];
        if (r_state == F_E2) r_e  <= prod2[32:16];
    end

endmodule

// ===== rtl/ctcgd_queue.sv =====
// ctcgd_queue: two-entry queue of finished timestep records between front and back
// depends on ctcgd_pkg
module ctcgd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ctcgd_pkg::t_step_rec i_rec,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_nonempty,
    output ctcgd_pkg::t_step_rec o_rec
);
    import ctcgd_pkg::*;

    t_step_rec  r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_rec      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

endmodule

// ===== rtl/ctcgd_divider.sv =====
// ctcgd_divider: restoring divider, one quotient bit per cycle, with rounding done by the caller
// depends on ctcgd_pkg
module ctcgd_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ctcgd_pkg::DIV_NW-1:0]   i_num,
    input  logic [ctcgd_pkg::DIV_DW-1:0]   i_den,
    output logic                           o_done,
    output logic [ctcgd_pkg::DIV_NW-1:0]   o_quot
);
    import ctcgd_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   r_rem;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;

    assign rem_sh = {r_rem[DIV_DW-1:0], r_q[DIV_NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign o_quot = r_q;
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_NW);
        end else if (r_busy) begin
            if (r_cnt == '0) r_busy <= 1'b0;
            else             r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_q   <= {r_q[DIV_NW-2:0], ge};
        end
    end

endmodule

// ===== rtl/ctcgd_back.sv =====
// ctcgd_back: collapses repeats and blanks, forms probabilities and the sequence verdict
// depends on ctcgd_pkg, ctcgd_divider
module ctcgd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_nonempty,
    input  ctcgd_pkg::t_step_rec           i_rec,
    output logic                           o_pop,
    input  logic [16:0]                    i_conf_threshold,
    input  logic [7:0]                     i_vocab_entries,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_kind,
    output logic [6:0]                     o_char_index,
    output logic                           o_out_of_vocab,
    output logic [16:0]                    o_confidence,
    output logic                           o_accepted,
    output logic                           o_last
);
    import ctcgd_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_EVAL = 3'd1;
    localparam logic [2:0] B_PDIV = 3'd2;
    localparam logic [2:0] B_CHAR = 3'd3;
    localparam logic [2:0] B_AVG  = 3'd4;
    localparam logic [2:0] B_ADIV = 3'd5;
    localparam logic [2:0] B_VERD = 3'd6;

    logic [2:0]       r_state, n_state;
    t_step_rec        r_rec;
    logic [CLS_W-1:0] r_prev;
    logic [TOT_W-1:0] r_total;
    logic [CNT_W-1:0] r_count;
    logic [Q_W-1:0]   r_prob, r_avg;

    logic              out_free, emit, raw, div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den;
    logic [Q_W-1:0]    quot_sat;

    assign out_free = !o_valid || !i_stall;
    assign o_pop    = (r_state == B_IDLE) && i_nonempty;
    assign emit     = (r_rec.cls != r_prev) && (r_rec.cls != '0);
    assign raw      = (r_rec.scr >= 0) && (r_rec.scr <= 16'sd256);
    assign quot_sat = (div_quot > DIV_NW'(Q_ONE)) ? Q_ONE : div_quot[Q_W-1:0];

    assign div_start = ((r_state == B_EVAL) && emit && !raw)
                    || ((r_state == B_AVG) && (r_count != '0));
    always_comb begin
        if (r_state == B_EVAL) begin
            div_num = 34'h1_0000_0000 + DIV_NW'(r_rec.sum >> 1);
            div_den = DIV_DW'(r_rec.sum);
        end else begin
            div_num = DIV_NW'(r_total) + DIV_NW'(r_count >> 1);
            div_den = DIV_DW'(r_count);
        end
    end

    ctcgd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_nonempty) n_state = B_EVAL;
            B_EVAL: begin
                if (emit)               n_state = raw ? B_CHAR : B_PDIV;
                else if (r_rec.seq_end) n_state = B_AVG;
                else                    n_state = B_IDLE;
            end
            B_PDIV: if (div_done) n_state = B_CHAR;
            B_CHAR: if (out_free) n_state = r_rec.seq_end ? B_AVG : B_IDLE;
            B_AVG:  n_state = (r_count != '0) ? B_ADIV : B_VERD;
            B_ADIV: if (div_done) n_state = B_VERD;
            B_VERD: if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_prev  <= '0;
            r_total <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_CHAR || r_state == B_VERD) && out_free) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            unique case (r_state)
                B_EVAL: if (!emit) r_prev <= r_rec.cls;
                B_CHAR: if (out_free) begin
                    r_prev  <= r_rec.cls;
                    if (r_count < CNT_TOP) begin
                        r_count <= r_count + 1'b1;
                        r_total <= r_total + TOT_W'(r_prob);
                    end
                end
                B_VERD: if (out_free) begin
                    r_prev  <= '0;
                    r_total <= '0;
                    r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_rec <= i_rec;
        if (r_state == B_EVAL && raw) r_prob <= {r_rec.scr[8:0], 8'h00};
        if (r_state == B_PDIV && div_done) r_prob <= quot_sat;
        if (r_state == B_AVG) r_avg <= '0;
        if (r_state == B_ADIV && div_done) r_avg <= quot_sat;
        if (r_state == B_CHAR && out_free) begin
            o_kind         <= KIND_CHAR;
            o_char_index   <= CHAR_W'(r_rec.cls);
            o_out_of_vocab <= 32'(r_rec.cls) >= 32'(i_vocab_entries);
            o_confidence   <= r_prob;
            o_accepted     <= 1'b0;
            o_last         <= 1'b0;
        end
        if (r_state == B_VERD && out_free) begin
            o_kind         <= KIND_VERDICT;
            o_char_index   <= '0;
            o_out_of_vocab <= 1'b0;
            o_confidence   <= r_avg;
            o_accepted     <= (r_count != '0) && (r_avg >= i_conf_threshold);
            o_last         <= 1'b1;
        end
    end

endmodule

// ===== rtl/ctc_greedy_decoder.sv =====
// ctc_greedy_decoder: top level, config registers and front/queue/back wiring
// depends on ctcgd_pkg, ctcgd_front, ctcgd_queue, ctcgd_back
//
// Input channel: one beat per class score (signed Q8.8), classes of a
// timestep in index order, last_in_step closing a timestep and
// last_in_sequence closing the sequence. A score beat is taken on
// i_in_valid with o_in_stall low; the front unit works through each score
// in turn (exp table products then the exp-sum multiply) and takes no new
// score until it has finished the last one.
// Output channel: a character beat for each new non-blank class and a
// verdict beat (last = 1) at sequence end. Softmax confidence uses a
// bit-serial divider; with the back idle and no stall, a character beat
// follows its closing score through the front, the queue and the back
// (and the divider when used), and a verdict follows that character beat.
// A two-entry queue of timestep records lets the front keep taking scores
// while the back waits on the divider or on i_out_stall; while the
// receiver stalls, the output beat holds and the back waits to emit.
// Reset (synchronous, active low) clears all decoding state, sets the
// threshold to zero and the vocabulary size to one.
module ctc_greedy_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_score,
    input  logic               i_last_in_step,
    input  logic               i_last_in_sequence,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_kind,
    output logic [6:0]         o_char_index,
    output logic               o_out_of_vocab,
    output logic [16:0]        o_confidence,
    output logic               o_accepted,
    output logic               o_last
);
    import ctcgd_pkg::*;

    logic [16:0] r_conf_threshold;
    logic [7:0]  r_vocab_entries;
    logic        push, pop, full, nonempty;
    t_step_rec   push_rec, pop_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_threshold <= '0;
            r_vocab_entries  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_conf_threshold <= i_cfg_data;
                REG_VOCAB:     r_vocab_entries  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ctcgd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_score            (i_score),
        .i_last_in_step     (i_last_in_step),
        .i_last_in_sequence (i_last_in_sequence),
        .o_push             (push),
        .o_rec              (push_rec),
        .i_full             (full)
    );

    ctcgd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rec      (push_rec),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_rec      (pop_rec)
    );

    ctcgd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_nonempty       (nonempty),
        .i_rec            (pop_rec),
        .o_pop            (pop),
        .i_conf_threshold (r_conf_threshold),
        .i_vocab_entries  (r_vocab_entries),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_kind           (o_kind),
        .o_char_index     (o_char_index),
        .o_out_of_vocab   (o_out_of_vocab),
        .o_confidence     (o_confidence),
        .o_accepted       (o_accepted),
        .o_last           (o_last)
    );

endmodule

// ===== rtl/ctcgd_checker.sv =====
// ctcgd_checker: port-level assertions on the decoder output channel, bound to the top level
// depends on ctcgd_pkg
module ctcgd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_kind,
    input logic [6:0]  o_char_index,
    input logic        o_out_of_vocab,
    input logic [16:0] o_confidence,
    input logic        o_accepted,
    input logic        o_last
);
    import ctcgd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_last_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == o_last))
        else $error("last flag not on verdict beat");

    a_char_nonblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_CHAR) |-> (o_char_index != 7'd0) && !o_accepted)
        else $error("character beat carries blank or accept");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_VERDICT) |-> (o_char_index == 7'd0) && !o_out_of_vocab)
        else $error("verdict beat carries character fields");

    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_confidence <= Q_ONE))
        else $error("confidence above one");

endmodule

bind ctc_greedy_decoder ctcgd_checker u_checker (.*);
